// ----- rtl/core/rlws_pkg.sv -----
// Shared types, constants and helpers for the RAM loader write sequencer.
// No dependencies; the datapath, controller, top and testbench import this package.
package rlws_pkg;

  localparam int WORDS          = 16;
  localparam int DELAY_BITS     = 16;
  localparam int CFG_BITS       = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int WA_BITS        = $clog2(WORDS + 1);
  localparam int IDX_BITS       = (WORDS > 1) ? $clog2(WORDS) : 1;

  localparam logic [CFG_BITS-1:0] START_DELAY_RST = CFG_BITS'(500);
  localparam logic [CFG_BITS-1:0] SHORT_DELAY_RST = CFG_BITS'(10);
  localparam logic [CFG_BITS-1:0] LONG_DELAY_RST  = CFG_BITS'(50);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_START_DELAY = 2'd0,
    REG_SHORT_DELAY = 2'd1,
    REG_LONG_DELAY  = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_START = 2'd2,
    CMD_ABORT = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_CLOCK = 2'd1,
    ERR_RAM   = 2'd2
  } err_t;

  typedef enum logic [3:0] {
    PH_CTRL_ON   = 4'd0,
    PH_DATA_ON   = 4'd1,
    PH_SET_WORD  = 4'd2,
    PH_WRITE_HI  = 4'd3,
    PH_WRITE_LO  = 4'd4,
    PH_RESET_ON  = 4'd5,
    PH_RESET_OFF = 4'd6,
    PH_DATA_OFF  = 4'd7,
    PH_CTRL_OFF  = 4'd8,
    PH_FINISH    = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    DLY_START = 2'd0,
    DLY_SHORT = 2'd1,
    DLY_LONG  = 2'd2
  } dly_sel_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic     store_we;
    logic     dly_load;
    dly_sel_t dly_sel;
    logic     dly_dec;
    logic     dly_clear;
    logic     start_clear;
    logic     ctrl_set;
    logic     ctrl_clr;
    logic     data_set;
    logic     data_clr;
    logic     word_set;
    logic     wr_set;
    logic     wr_clr;
    logic     addr_inc;
    logic     rst_set;
    logic     rst_clr;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic delay_expire;
    logic word_pending;
    logic word_pending_next;
  } dp_status_t;

  typedef struct packed {
    logic       ctrl;
    logic       data;
    logic [3:0] addr;
    logic [7:0] value;
    logic       write;
    logic       reset;
  } pins_t;

  // Saturate a programmed delay to the counter range
  function automatic logic [DELAY_BITS-1:0] arm(input logic [CFG_BITS-1:0] ticks);
    logic [63:0] t64;
    logic [63:0] max64;
    t64   = 64'(ticks);
    max64 = (64'd1 << DELAY_BITS) - 64'd1;
    return DELAY_BITS'((t64 > max64) ? max64 : t64);
  endfunction

endpackage

// ----- rtl/core/rlws_chan_if.sv -----
// Valid/ready channel interfaces for the RAM loader write sequencer.
// Depends on nothing; one interface for input items, one for results.
interface rlws_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [3:0] word_address;
  logic [7:0] word_value;
  logic       clock_manual;
  logic       ram_run;

  modport source (output valid, cmd, word_address, word_value, clock_manual, ram_run,
                  input ready);
  modport sink   (input valid, cmd, word_address, word_value, clock_manual, ram_run,
                  output ready);
endinterface

interface rlws_out_if;
  logic       valid;
  logic       ready;
  logic       control_enable;
  logic       data_enable;
  logic [3:0] ram_address;
  logic [7:0] ram_value;
  logic       ram_write;
  logic       reset_press;
  logic       busy_res;
  logic       done_res;
  logic [1:0] error;

  modport source (output valid, control_enable, data_enable, ram_address, ram_value,
                  ram_write, reset_press, busy_res, done_res, error,
                  input ready);
  modport sink   (input valid, control_enable, data_enable, ram_address, ram_value,
                  ram_write, reset_press, busy_res, done_res, error,
                  output ready);
endinterface

// ----- rtl/core/rlws_dp.sv -----
// Datapath of the RAM loader write sequencer: config registers, program
// store, delay counter, word index and pin registers. Depends on rlws_pkg.
module rlws_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [rlws_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [rlws_pkg::CFG_BITS-1:0]       cfg_data,
  input  rlws_pkg::dp_cmd_t                  cmd,
  input  logic [3:0]                         word_address,
  input  logic [7:0]                         word_value,
  output rlws_pkg::dp_status_t               status,
  output rlws_pkg::pins_t                    pins
);
  import rlws_pkg::*;

  logic [CFG_BITS-1:0]   start_delay_r, short_delay_r, long_delay_r;
  logic [DELAY_BITS-1:0] delay_r, delay_nxt;
  logic [WA_BITS-1:0]    waddr_r, waddr_nxt;
  pins_t                 pins_r, pins_nxt;
  logic [7:0]            store [WORDS];
  logic [CFG_BITS-1:0]   dly_src;
  logic [WA_BITS:0]      waddr_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_delay_r <= START_DELAY_RST;
      short_delay_r <= SHORT_DELAY_RST;
      long_delay_r  <= LONG_DELAY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_DELAY: start_delay_r <= cfg_data;
        REG_SHORT_DELAY: short_delay_r <= cfg_data;
        REG_LONG_DELAY:  long_delay_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_we && (32'(word_address) < WORDS)) begin
      store[IDX_BITS'(word_address)] <= word_value;
    end
  end

  assign waddr_inc = {1'b0, waddr_r} + (WA_BITS+1)'(1);

  assign status.delay_expire      = (delay_r <= DELAY_BITS'(1));
  assign status.word_pending      = (waddr_r < WA_BITS'(WORDS));
  assign status.word_pending_next = (waddr_inc < (WA_BITS+1)'(WORDS));

  always_comb begin
    case (cmd.dly_sel)
      DLY_START: dly_src = start_delay_r;
      DLY_LONG:  dly_src = long_delay_r;
      default:   dly_src = short_delay_r;
    endcase
  end

  always_comb begin
    delay_nxt = delay_r;
    waddr_nxt = waddr_r;
    pins_nxt  = pins_r;
    // load wins over clear and count
    if (cmd.dly_load) begin
      delay_nxt = arm(dly_src);
    end else if (cmd.dly_clear) begin
      delay_nxt = '0;
    end else if (cmd.dly_dec && (delay_r != '0)) begin
      delay_nxt = delay_r - DELAY_BITS'(1);
    end
    if (cmd.start_clear) begin
      waddr_nxt      = '0;
      pins_nxt.write = 1'b0;
      pins_nxt.reset = 1'b0;
      pins_nxt.addr  = '0;
      pins_nxt.value = '0;
    end
    if (cmd.addr_inc) waddr_nxt = WA_BITS'(waddr_inc);
    if (cmd.ctrl_set) pins_nxt.ctrl = 1'b1;
    if (cmd.ctrl_clr) pins_nxt.ctrl = 1'b0;
    if (cmd.data_set) pins_nxt.data = 1'b1;
    if (cmd.data_clr) pins_nxt.data = 1'b0;
    if (cmd.word_set) pins_nxt.addr = 4'(waddr_r);
    if (cmd.wr_set)  pins_nxt.write = 1'b1;
    if (cmd.wr_clr)  pins_nxt.write = 1'b0;
    if (cmd.rst_set) pins_nxt.reset = 1'b1;
    if (cmd.rst_clr) pins_nxt.reset = 1'b0;
  end

  // The value pin takes the store word straight from the store read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= '0;
      waddr_r <= '0;
      pins_r  <= '0;
    end else begin
      delay_r <= delay_nxt;
      waddr_r <= waddr_nxt;
      pins_r  <= '{ctrl:  pins_nxt.ctrl,
                   data:  pins_nxt.data,
                   addr:  pins_nxt.addr,
                   value: cmd.word_set
                            ? (status.word_pending ? store[IDX_BITS'(waddr_r)] : 8'd0)
                            : pins_nxt.value,
                   write: pins_nxt.write,
                   reset: pins_nxt.reset};
    end
  end

  assign pins = pins_r;

endmodule

// ----- rtl/core/rlws_ctrl.sv -----
// Controller of the RAM loader write sequencer: step state machine, busy,
// done and error flags. Depends on rlws_pkg; drives rlws_dp by command.
module rlws_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  rlws_pkg::cmd_t       cmd,
  input  logic                 clock_manual,
  input  logic                 ram_run,
  input  rlws_pkg::dp_status_t status,
  output rlws_pkg::dp_cmd_t    dp_cmd,
  output logic                 busy,
  output logic                 done,
  output rlws_pkg::err_t       error,
  output rlws_pkg::phase_t     phase
);
  import rlws_pkg::*;

  phase_t phase_r, phase_nxt;
  logic   busy_r, busy_nxt;
  logic   done_r, done_nxt;
  err_t   err_r, err_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_CTRL_ON;
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      err_r   <= ERR_NONE;
    end else begin
      phase_r <= phase_nxt;
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      err_r   <= err_nxt;
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    busy_nxt       = busy_r;
    done_nxt       = done_r;
    err_nxt        = err_r;
    dp_cmd         = '0;
    dp_cmd.dly_sel = DLY_SHORT;
    if (accept) begin
      done_nxt = 1'b0;
      err_nxt  = ERR_NONE;
      case (cmd)
        CMD_TICK: begin
          if (busy_r) begin
            dp_cmd.dly_dec = 1'b1;
            if (status.delay_expire) begin
              dp_cmd.dly_load = 1'b1;
              case (phase_r)
                PH_CTRL_ON: begin
                  dp_cmd.ctrl_set = 1'b1;
                  phase_nxt       = PH_DATA_ON;
                end
                PH_DATA_ON: begin
                  dp_cmd.data_set = 1'b1;
                  phase_nxt       = status.word_pending ? PH_SET_WORD : PH_RESET_ON;
                end
                PH_SET_WORD: begin
                  dp_cmd.word_set = 1'b1;
                  phase_nxt       = PH_WRITE_HI;
                end
                PH_WRITE_HI: begin
                  dp_cmd.wr_set = 1'b1;
                  phase_nxt     = PH_WRITE_LO;
                end
                PH_WRITE_LO: begin
                  dp_cmd.wr_clr   = 1'b1;
                  dp_cmd.addr_inc = 1'b1;
                  dp_cmd.dly_sel  = DLY_LONG;
                  phase_nxt       = status.word_pending_next ? PH_SET_WORD : PH_RESET_ON;
                end
                PH_RESET_ON: begin
                  dp_cmd.rst_set = 1'b1;
                  phase_nxt      = PH_RESET_OFF;
                end
                PH_RESET_OFF: begin
                  dp_cmd.rst_clr = 1'b1;
                  dp_cmd.dly_sel = DLY_LONG;
                  phase_nxt      = PH_DATA_OFF;
                end
                PH_DATA_OFF: begin
                  dp_cmd.data_clr = 1'b1;
                  phase_nxt       = PH_CTRL_OFF;
                end
                PH_CTRL_OFF: begin
                  dp_cmd.ctrl_clr = 1'b1;
                  phase_nxt       = PH_FINISH;
                end
                default: begin
                  // finish: drop busy, rewind and zero the counter
                  dp_cmd.dly_load  = 1'b0;
                  dp_cmd.dly_clear = 1'b1;
                  busy_nxt         = 1'b0;
                  done_nxt         = 1'b1;
                  phase_nxt        = PH_CTRL_ON;
                end
              endcase
            end
          end
        end
        CMD_LOAD: dp_cmd.store_we = 1'b1;
        CMD_START: begin
          if (!busy_r) begin
            if (!clock_manual) begin
              err_nxt = ERR_CLOCK;
            end else if (!ram_run) begin
              err_nxt = ERR_RAM;
            end else begin
              phase_nxt          = PH_CTRL_ON;
              busy_nxt           = 1'b1;
              dp_cmd.start_clear = 1'b1;
              dp_cmd.dly_load    = 1'b1;
              dp_cmd.dly_sel     = DLY_START;
            end
          end
        end
        CMD_ABORT: begin
          busy_nxt        = 1'b0;
          dp_cmd.ctrl_clr = 1'b1;
          dp_cmd.data_clr = 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign busy  = busy_r;
  assign done  = done_r;
  assign error = err_r;
  assign phase = phase_r;

endmodule

// ----- rtl/core/ram_loader_write_sequencer.sv -----
// An accepted item's result is registered and offered in the cycle after it;
// one item per cycle while results are taken. The state is the result register,
// so an item is taken if no result is held or it leaves; a tick runs at most one step.
// Reset (rst_n low, synchronous): idle, pins low, delays 500/10/50 ticks,
// no result pending; the program store keeps whatever it held.
module ram_loader_write_sequencer (
  input  logic                               clk,
  input  logic                               rst_n,
  rlws_in_if.sink                            in_ch,
  rlws_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [rlws_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [rlws_pkg::CFG_BITS-1:0]       cfg_data
);
  import rlws_pkg::*;

  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;
  pins_t      pins;
  logic       busy_w, done_w;
  err_t       err_w;
  phase_t     phase_w;
  cmd_t       cmd_w;

  // Take a new item whenever the held result is gone or leaving now
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign cmd_w       = cmd_t'(in_ch.cmd);

  rlws_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .cmd          (cmd_w),
    .clock_manual (in_ch.clock_manual),
    .ram_run      (in_ch.ram_run),
    .status       (dp_status),
    .dp_cmd       (dp_cmd),
    .busy         (busy_w),
    .done         (done_w),
    .error        (err_w),
    .phase        (phase_w)
  );

  rlws_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (dp_cmd),
    .word_address (in_ch.word_address),
    .word_value   (in_ch.word_value),
    .status       (dp_status),
    .pins         (pins)
  );

  // Hold valid until taken; an accepted item always yields one result
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // The state registers only move on an accepted item, so they are the result
  assign out_ch.valid          = out_valid_r;
  assign out_ch.control_enable = pins.ctrl;
  assign out_ch.data_enable    = pins.data;
  assign out_ch.ram_address    = pins.addr;
  assign out_ch.ram_value      = pins.value;
  assign out_ch.ram_write      = pins.write;
  assign out_ch.reset_press    = pins.reset;
  assign out_ch.busy_res       = busy_w;
  assign out_ch.done_res       = done_w;
  assign out_ch.error          = err_w;

  // Finishing always leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_w |-> !busy_w)
    else $error("done flagged while still busy");

  // A refused start only happens from idle and leaves it idle
  a_err_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (err_w != ERR_NONE) |-> (!busy_w && $past(!busy_w)))
    else $error("start refused while busy or busy set on refusal");

  // While running, the write strobe is high only between raise and lower
  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_w && pins.write) |-> (phase_w == PH_WRITE_LO))
    else $error("write strobe high outside the write pulse");

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the RAM loader write sequencer.
// Depends on rlws_pkg, the rlws_in_if / rlws_out_if channels and the block.
// An in-bench predictor tracks the sequencer; every result is checked against it.
module testbench;
  import rlws_pkg::*;

  // One command item as the predictor sees it
  typedef struct packed {
    cmd_t       cmd;
    logic [3:0] word_address;
    logic [7:0] word_value;
    logic       clock_manual;
    logic       ram_run;
  } loader_item_t;

  // Pin levels and status reported after one item
  typedef struct packed {
    pins_t pins;
    logic  busy;
    logic  done;
    err_t  err;
  } pin_report_t;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0]       cfg_data;

  rlws_in_if  in_ch ();
  rlws_out_if out_ch ();

  ram_loader_write_sequencer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor state: program store, sequence position, pins and delay registers
  logic [7:0]            prog_mem [WORDS];
  logic                  seq_busy;
  phase_t                seq_phase;
  logic [WA_BITS-1:0]    word_idx;
  logic [DELAY_BITS-1:0] ticks_left;
  pins_t                 pin_state;
  logic [CFG_BITS-1:0]   dly_start;
  logic [CFG_BITS-1:0]   dly_short;
  logic [CFG_BITS-1:0]   dly_long;

  // Reports predicted for accepted items, oldest first
  pin_report_t pending_reports [$];
  int          mismatch_count;

  // Percent of cycles in which the sender idles and the receiver stalls
  int in_gap_pct;
  int out_stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run; far above the slowest correct run
  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Bring a programmed delay into the counter range
  function automatic logic [DELAY_BITS-1:0] clamp_ticks(input logic [CFG_BITS-1:0] t);
    if (CFG_BITS > DELAY_BITS && t > {DELAY_BITS{1'b1}}) return '1;
    return DELAY_BITS'(t);
  endfunction

  // Run the step the sequence is waiting on; return 1 on the finish step
  function automatic logic run_next_step();
    case (seq_phase)
      PH_CTRL_ON: begin
        pin_state.ctrl = 1'b1;
        ticks_left     = clamp_ticks(dly_short);
        seq_phase      = PH_DATA_ON;
      end
      PH_DATA_ON: begin
        pin_state.data = 1'b1;
        ticks_left     = clamp_ticks(dly_short);
        seq_phase      = (word_idx < WORDS) ? PH_SET_WORD : PH_RESET_ON;
      end
      PH_SET_WORD: begin
        pin_state.addr  = word_idx[3:0];
        pin_state.value = (word_idx < WORDS) ? prog_mem[word_idx[3:0]] : 8'h00;
        ticks_left      = clamp_ticks(dly_short);
        seq_phase       = PH_WRITE_HI;
      end
      PH_WRITE_HI: begin
        pin_state.write = 1'b1;
        ticks_left      = clamp_ticks(dly_short);
        seq_phase       = PH_WRITE_LO;
      end
      PH_WRITE_LO: begin
        // Release write, move to the next word and wait the long delay
        pin_state.write = 1'b0;
        word_idx        = word_idx + 1'b1;
        ticks_left      = clamp_ticks(dly_long);
        seq_phase       = (word_idx < WORDS) ? PH_SET_WORD : PH_RESET_ON;
      end
      PH_RESET_ON: begin
        pin_state.reset = 1'b1;
        ticks_left      = clamp_ticks(dly_short);
        seq_phase       = PH_RESET_OFF;
      end
      PH_RESET_OFF: begin
        pin_state.reset = 1'b0;
        ticks_left      = clamp_ticks(dly_long);
        seq_phase       = PH_DATA_OFF;
      end
      PH_DATA_OFF: begin
        pin_state.data = 1'b0;
        ticks_left     = clamp_ticks(dly_short);
        seq_phase      = PH_CTRL_OFF;
      end
      PH_CTRL_OFF: begin
        pin_state.ctrl = 1'b0;
        ticks_left     = clamp_ticks(dly_short);
        seq_phase      = PH_FINISH;
      end
      default: begin
        seq_busy   = 1'b0;
        seq_phase  = PH_CTRL_ON;
        ticks_left = '0;
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  // Advance the predictor by one item and return the report it should cause
  function automatic pin_report_t apply_item(input loader_item_t it);
    pin_report_t r;
    r.err  = ERR_NONE;
    r.done = 1'b0;
    case (it.cmd)
      CMD_TICK: begin
        if (seq_busy) begin
          if (ticks_left != '0) ticks_left = ticks_left - 1'b1;
          if (ticks_left == '0) r.done = run_next_step();
        end
      end
      CMD_LOAD: begin
        prog_mem[it.word_address] = it.word_value;
      end
      CMD_START: begin
        // Busy: ignore. Clock switch is checked before the RAM switch.
        if (!seq_busy) begin
          if (!it.clock_manual) begin
            r.err = ERR_CLOCK;
          end else if (!it.ram_run) begin
            r.err = ERR_RAM;
          end else begin
            seq_phase       = PH_CTRL_ON;
            word_idx        = '0;
            pin_state.write = 1'b0;
            pin_state.reset = 1'b0;
            pin_state.addr  = '0;
            pin_state.value = '0;
            ticks_left      = clamp_ticks(dly_start);
            seq_busy        = 1'b1;
          end
        end
      end
      default: begin
        // Abort drops both enables, leaves the other pins alone
        seq_busy       = 1'b0;
        pin_state.data = 1'b0;
        pin_state.ctrl = 1'b0;
      end
    endcase
    r.pins = pin_state;
    r.busy = seq_busy;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving and checking
  // ---------------------------------------------------------------------------

  // Drive one item from a falling edge, hold it until accepted, then predict
  task automatic send_item(input cmd_t op, input logic [3:0] addr, input logic [7:0] value,
                           input logic manual, input logic run);
    loader_item_t it;
    it = '{cmd: op, word_address: addr, word_value: value, clock_manual: manual,
           ram_run: run};
    @(negedge clk);
    while ($urandom_range(99) < in_gap_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid        = 1'b1;
    in_ch.cmd          = it.cmd;
    in_ch.word_address = it.word_address;
    in_ch.word_value   = it.word_value;
    in_ch.clock_manual = it.clock_manual;
    in_ch.ram_run      = it.ram_run;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_reports.push_back(apply_item(it));
  endtask

  // Send a command with every other field random
  task automatic send_random(input cmd_t op);
    send_item(op, 4'($urandom_range(15)), 8'($urandom_range(255)),
              1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  // Send a start that passes both switch checks
  task automatic send_good_start();
    send_item(CMD_START, 4'($urandom_range(15)), 8'($urandom_range(255)), 1'b1, 1'b1);
  endtask

  // Send a start that one of the switches refuses
  task automatic send_refused_start();
    logic manual;
    manual = 1'($urandom_range(1));
    send_item(CMD_START, 4'($urandom_range(15)), 8'($urandom_range(255)), manual,
              manual ? 1'b0 : 1'($urandom_range(1)));
  endtask

  // Drop valid and hold off until every predicted report has come back
  task automatic wait_for_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Reprogram all three delays; only ever done with the block drained
  task automatic write_delays(input logic [CFG_BITS-1:0] start_val,
                              input logic [CFG_BITS-1:0] short_val,
                              input logic [CFG_BITS-1:0] long_val);
    reg_idx_t idx;
    wait_for_results();
    for (int i = 0; i < 3; i++) begin
      idx = reg_idx_t'(i);
      @(negedge clk);
      cfg_we    = 1'b1;
      cfg_index = idx;
      case (idx)
        REG_START_DELAY: begin
          cfg_data  = start_val;
          dly_start = start_val;
        end
        REG_SHORT_DELAY: begin
          cfg_data  = short_val;
          dly_short = short_val;
        end
        default: begin
          cfg_data = long_val;
          dly_long = long_val;
        end
      endcase
    end
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Receiver: stall at random, decided at the falling edge
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = ($urandom_range(99) >= out_stall_pct);
    end
  end

  // Compare every accepted report against the oldest prediction
  always @(posedge clk) begin : result_check
    pin_report_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result, expected none, got ctrl %0d data %0d addr %0d",
                 $time, out_ch.control_enable, out_ch.data_enable, out_ch.ram_address);
        mismatch_count++;
      end else begin
        want = pending_reports.pop_front();
        check_field("control_enable", want.pins.ctrl,  out_ch.control_enable);
        check_field("data_enable",    want.pins.data,  out_ch.data_enable);
        check_field("ram_address",    want.pins.addr,  out_ch.ram_address);
        check_field("ram_value",      want.pins.value, out_ch.ram_value);
        check_field("ram_write",      want.pins.write, out_ch.ram_write);
        check_field("reset_press",    want.pins.reset, out_ch.reset_press);
        check_field("busy_res",       want.busy,       out_ch.busy_res);
        check_field("done_res",       want.done,       out_ch.done_res);
        check_field("error",          want.err,        out_ch.error);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Commands to an idle block: tick and abort change nothing but the enables;
  // both refusal codes, with the clock switch taking priority
  task automatic test_idle_commands();
    send_item(CMD_TICK,  4'hF, 8'hFF, 1'b1, 1'b1);
    send_item(CMD_ABORT, 4'h0, 8'h00, 1'b0, 1'b0);
    send_item(CMD_START, 4'h0, 8'h00, 1'b0, 1'b1);
    send_item(CMD_START, 4'hF, 8'hFF, 1'b0, 1'b0);
    send_item(CMD_START, 4'h5, 8'hA5, 1'b1, 1'b0);
  endtask

  // Fill every store entry so later sequences never read an unwritten word
  task automatic test_program_load();
    logic [7:0] value;
    for (int i = 0; i < WORDS; i++) begin
      case (i)
        0:       value = 8'h00;
        1:       value = 8'hFF;
        2:       value = 8'h55;
        3:       value = 8'hAA;
        default: value = 8'($urandom_range(255));
      endcase
      send_item(CMD_LOAD, 4'(i), value, 1'($urandom_range(1)), 1'($urandom_range(1)));
    end
  endtask

  // All delays zero: every tick runs a step. Poke a busy start and a late
  // store write into the middle of the run.
  task automatic test_zero_delay_run();
    int n;
    write_delays('0, '0, '0);
    send_good_start();
    n = 0;
    while (seq_busy) begin
      n++;
      if (n == 10) send_good_start();
      else if (n == 20) send_item(CMD_LOAD, 4'hF, 8'h3C, 1'b1, 1'b1);
      else send_random(CMD_TICK);
    end
  endtask

  // Abort with write high mid-program: enables drop, other pins hold;
  // a fresh start then clears the held pins
  task automatic test_abort_keeps_pins();
    write_delays(16'd2, 16'd1, 16'd1);
    send_good_start();
    while (!(pin_state.write && word_idx == 5)) send_random(CMD_TICK);
    send_random(CMD_ABORT);
    send_random(CMD_TICK);
    send_good_start();
    repeat (3) send_random(CMD_TICK);
    send_random(CMD_ABORT);
  endtask

  // Largest count in each register: reach the wait on it, tick a little, abort
  task automatic test_delay_extremes();
    write_delays(16'hFFFF, 16'd1, 16'd1);
    send_good_start();
    repeat (4) send_random(CMD_TICK);
    send_random(CMD_ABORT);

    write_delays(16'd1, 16'hFFFF, 16'd1);
    send_good_start();
    repeat (5) send_random(CMD_TICK);
    send_random(CMD_ABORT);

    write_delays(16'd1, 16'd1, 16'hFFFF);
    send_good_start();
    while (word_idx == 0) send_random(CMD_TICK);
    repeat (4) send_random(CMD_TICK);
    send_random(CMD_ABORT);
  endtask

  // Mostly complete load sequences with random delays and content, mixed with
  // idle noise, refused and busy starts, stray loads and the odd abort
  task automatic test_random_traffic(input int quota);
    int sent;
    int pick;
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(1))
        write_delays(16'($urandom_range(6)), 16'($urandom_range(2)),
                     16'($urandom_range(3)));
      // Noise while idle
      repeat ($urandom_range(3)) begin
        pick = $urandom_range(3);
        case (pick)
          0:       send_random(CMD_TICK);
          1:       send_random(CMD_ABORT);
          2:       send_random(CMD_LOAD);
          default: send_refused_start();
        endcase
        if (pick != 0) sent++;
      end
      send_good_start();
      sent++;
      while (seq_busy) begin
        pick = $urandom_range(299);
        if (pick == 0) send_random(CMD_ABORT);
        else if (pick < 20) send_random(CMD_LOAD);
        else if (pick < 28) send_random(CMD_START);
        else send_random(CMD_TICK);
        sent++;
      end
      // Now and then, hold the sender until the block has drained
      if ($urandom_range(3) == 0) wait_for_results();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    mismatch_count     = 0;
    in_gap_pct         = 26;
    out_stall_pct      = 83;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = REG_START_DELAY;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.cmd          = CMD_TICK;
    in_ch.word_address = '0;
    in_ch.word_value   = '0;
    in_ch.clock_manual = 1'b0;
    in_ch.ram_run      = 1'b0;

    // Predictor mirrors the reset state; the store is filled before any run
    seq_busy   = 1'b0;
    seq_phase  = PH_CTRL_ON;
    word_idx   = '0;
    ticks_left = '0;
    pin_state  = '0;
    dly_start  = START_DELAY_RST;
    dly_short  = SHORT_DELAY_RST;
    dly_long   = LONG_DELAY_RST;
    for (int i = 0; i < WORDS; i++) prog_mem[i] = '0;

    // Hold reset low, then release it at a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_idle_commands();
    test_program_load();
    test_zero_delay_run();
    test_abort_keeps_pins();
    test_delay_extremes();
    test_random_traffic(320);

    // Swap the idle rates, then run with no idling at all
    in_gap_pct    = 83;
    out_stall_pct = 26;
    test_random_traffic(320);
    in_gap_pct    = 0;
    out_stall_pct = 0;
    test_random_traffic(340);

    wait_for_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
